// ===== sv/sfd_pkg.sv =====
`default_nettype none
package sfd_pkg;

    localparam logic [7:0] PRE_BYTE0  = 8'hAB;
    localparam logic [7:0] PRE_BYTE1  = 8'hCD;
    localparam logic [7:0] FOOT_BYTE0 = 8'hDC;
    localparam logic [7:0] FOOT_BYTE1 = 8'hBA;

    // header (2) + length (2) + crc (2) + footer (2)
    localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_CRC_BAD  = 2'd1;
    localparam t_status ST_FOOT_BAD = 2'd2;
    localparam t_status ST_OVERSIZE = 2'd3;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_DATA     = 2'd0;  // val[7:0] = descrambled byte
    localparam t_opcode OP_START    = 2'd1;  // val = crc seed
    localparam t_opcode OP_CHECK    = 2'd2;  // val = received crc, flag = footer ok
    localparam t_opcode OP_OVERSIZE = 2'd3;

    typedef struct packed {
        t_opcode     code;
        logic        flag;
        logic [15:0] val;
    } t_op;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic        descramble_enable;
        logic [15:0] crc_poly;
        logic [15:0] crc_seed;
    } t_cfg;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MAX_FRAME  = 2'd0;
    localparam t_reg_idx REG_DESCRAMBLE = 2'd1;
    localparam t_reg_idx REG_CRC_POLY   = 2'd2;
    localparam t_reg_idx REG_CRC_SEED   = 2'd3;

    function automatic logic [7:0] scramble_key(input logic [3:0] idx);
        logic [7:0] k;
        unique case (idx)
            4'd0:    k = 8'h16;
            4'd1:    k = 8'h6C;
            4'd2:    k = 8'h14;
            4'd3:    k = 8'hE6;
            4'd4:    k = 8'h2E;
            4'd5:    k = 8'h91;
            4'd6:    k = 8'h0D;
            4'd7:    k = 8'h40;
            4'd8:    k = 8'h21;
            4'd9:    k = 8'h35;
            4'd10:   k = 8'hD5;
            4'd11:   k = 8'h40;
            4'd12:   k = 8'h13;
            4'd13:   k = 8'h03;
            4'd14:   k = 8'hE9;
            default: k = 8'h80;
        endcase
        return k;
    endfunction

    // one byte of MSB-first CRC-16, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  d,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sfd_if.sv =====
`default_nettype none
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
    logic       frame_last;

    modport source (output valid, output out_kind, output data_byte,
                    output frame_status, output frame_last, input ready);
    modport sink   (input valid, input out_kind, input data_byte,
                    input frame_status, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== sv/sfd_front.sv =====
`default_nettype none
module sfd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    sfd_in_if.sink            i_rx,
    input  wire sfd_pkg::t_cfg i_cfg,
    input  wire logic         i_q_full,
    output logic              o_push,
    output sfd_pkg::t_op      o_op
);
    import sfd_pkg::*;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_PRE2    = 4'd1;
    localparam logic [3:0] PH_LEN_LO  = 4'd2;
    localparam logic [3:0] PH_LEN_HI  = 4'd3;
    localparam logic [3:0] PH_PAYLOAD = 4'd4;
    localparam logic [3:0] PH_CRC_LO  = 4'd5;
    localparam logic [3:0] PH_CRC_HI  = 4'd6;
    localparam logic [3:0] PH_FOOT0   = 4'd7;
    localparam logic [3:0] PH_FOOT1   = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] r_rcrc, n_rcrc;
    logic        r_foot_ok, n_foot_ok;

    logic        w_take;
    logic [7:0]  w_b;
    logic [15:0] w_len;
    logic [15:0] w_count_inc;
    logic [3:0]  w_crc_hi_idx;
    logic        w_op_valid;
    t_op         w_op;

    function automatic logic [7:0] descramble(input logic [7:0] b, input logic [3:0] pos,
                                              input logic en);
        return en ? (b ^ scramble_key(pos)) : b;
    endfunction

    assign i_rx.ready   = !i_q_full;
    assign w_take       = i_rx.valid && !i_q_full;
    assign w_b          = i_rx.rx_byte;
    assign w_len        = {w_b, r_len[7:0]};
    assign w_count_inc  = r_count + 16'd1;
    assign w_crc_hi_idx = r_len[3:0] + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_count    = r_count;
        n_rcrc     = r_rcrc;
        n_foot_ok  = r_foot_ok;
        w_op_valid = 1'b0;
        w_op       = '{code: OP_DATA, flag: 1'b0, val: 16'd0};
        unique case (r_phase)
            PH_PRE2: begin
                if (w_b == PRE_BYTE1) begin
                    n_phase = PH_LEN_LO;
                end else if (w_b != PRE_BYTE0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                n_len   = {8'd0, w_b};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len      = w_len;
                w_op_valid = 1'b1;
                if (({1'b0, w_len} + FRAME_OVERHEAD) > {1'b0, i_cfg.max_frame_bytes}) begin
                    w_op.code = OP_OVERSIZE;
                    n_phase   = PH_HUNT;
                end else begin
                    w_op.code = OP_START;
                    w_op.val  = i_cfg.crc_seed;
                    n_count   = 16'd0;
                    n_phase   = (w_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w_op_valid = 1'b1;
                w_op.code  = OP_DATA;
                w_op.val   = {8'd0, descramble(w_b, r_count[3:0], i_cfg.descramble_enable)};
                n_count    = w_count_inc;
                if (w_count_inc >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_rcrc  = {8'd0, descramble(w_b, r_len[3:0], i_cfg.descramble_enable)};
                n_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_rcrc  = {descramble(w_b, w_crc_hi_idx, i_cfg.descramble_enable),
                           r_rcrc[7:0]};
                n_phase = PH_FOOT0;
            end
            PH_FOOT0: begin
                n_foot_ok = (w_b == FOOT_BYTE0);
                n_phase   = PH_FOOT1;
            end
            PH_FOOT1: begin
                w_op_valid = 1'b1;
                w_op.code  = OP_CHECK;
                w_op.flag  = r_foot_ok && (w_b == FOOT_BYTE1);
                w_op.val   = r_rcrc;
                n_phase    = PH_HUNT;
            end
            default: begin
                n_phase = (w_b == PRE_BYTE0) ? PH_PRE2 : PH_HUNT;
            end
        endcase
    end

    assign o_push = w_take && w_op_valid;
    assign o_op   = w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len     <= 16'd0;
            r_count   <= 16'd0;
            r_foot_ok <= 1'b0;
        end else if (w_take) begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_count   <= n_count;
            r_foot_ok <= n_foot_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rcrc <= n_rcrc;
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_count < r_len))
        else $error("payload count reached length while still in payload");

endmodule
`default_nettype wire

// ===== sv/sfd_fifo.sv =====
`default_nettype none
module sfd_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire sfd_pkg::t_op i_op,
    input  wire logic         i_pop,
    output sfd_pkg::t_op      o_op,
    output logic              o_full,
    output logic              o_empty
);
    import sfd_pkg::*;

    t_op                r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== sv/sfd_back.sv =====
`default_nettype none
module sfd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sfd_pkg::t_op  i_op,
    input  wire logic          i_q_empty,
    input  wire logic [15:0]   i_crc_poly,
    output logic               o_pop,
    sfd_out_if.source          o_res
);
    import sfd_pkg::*;

    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_data;
    t_status     r_status;
    logic        r_last;
    logic [15:0] r_crc;

    logic        w_take;
    logic        w_emits;

    // START only reloads the crc; everything else produces a result
    assign w_take  = !i_q_empty && (!r_valid || o_res.ready);
    assign w_emits = (i_op.code != OP_START);
    assign o_pop   = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= w_emits;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            unique case (i_op.code)
                OP_DATA: begin
                    r_crc    <= crc16_byte(r_crc, i_op.val[7:0], i_crc_poly);
                    r_kind   <= 1'b0;
                    r_data   <= i_op.val[7:0];
                    r_status <= ST_OK;
                    r_last   <= 1'b0;
                end
                OP_START: begin
                    r_crc <= i_op.val;
                end
                OP_CHECK: begin
                    r_kind <= 1'b1;
                    r_data <= 8'd0;
                    r_last <= 1'b1;
                    if (!i_op.flag) begin
                        r_status <= ST_FOOT_BAD;
                    end else if (r_crc != i_op.val) begin
                        r_status <= ST_CRC_BAD;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
                default: begin
                    r_kind   <= 1'b1;
                    r_data   <= 8'd0;
                    r_status <= ST_OVERSIZE;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.out_kind     = r_kind;
    assign o_res.data_byte    = r_data;
    assign o_res.frame_status = r_status;
    assign o_res.frame_last   = r_last;

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_kind) |-> (!r_last && r_status == ST_OK))
        else $error("payload transaction carries status fields");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind) |-> (r_last && r_data == 8'd0))
        else $error("status transaction malformed");

endmodule
`default_nettype wire

// ===== sv/scrambled_frame_deframer_top.sv =====
`default_nettype none
// Serial frame deframer.
// i_rx: one received byte per transaction (valid/ready). The block hunts for
// the preamble AB CD, reads a little-endian 16-bit length, descrambles and
// forwards payload bytes, then checks CRC-16 and the DC BA footer.
// o_res: one transaction per payload byte (out_kind 0), and one status
// transaction (out_kind 1, frame_last 1) per frame: ok, crc bad, footer bad
// or oversize. On any error status the consumer drops the frame's bytes.
// Throughput: one byte per cycle while the queue is not full. A byte is
// classified and queued as an op when it is accepted, and the CRC unit and
// output register then take the op from the head of the queue.
// When o_res stalls, the queue absorbs up to four ops; i_rx.ready drops only
// when the queue is full. Bytes that queue no op are handled by the front
// end only.
// APB registers at 0x0 max_frame_bytes, 0x4 descramble_enable, 0x8 crc_poly,
// 0xC crc_seed. pready is tied high; write only while the block is idle.
// Reset (synchronous, active low) restores register defaults, empties the
// queue and the output register, and returns to preamble hunting.
module scrambled_frame_deframer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfd_in_if.sink           i_rx,
    sfd_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    logic     w_push, w_pop, w_full, w_empty;
    t_op      w_push_op, w_head_op;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_bytes   <= 16'd256;
            r_cfg.descramble_enable <= 1'b1;
            r_cfg.crc_poly          <= 16'h1021;
            r_cfg.crc_seed          <= 16'h0000;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_FRAME:  r_cfg.max_frame_bytes   <= pwdata[15:0];
                REG_DESCRAMBLE: r_cfg.descramble_enable <= pwdata[0];
                REG_CRC_POLY:   r_cfg.crc_poly          <= pwdata[15:0];
                default:        r_cfg.crc_seed          <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAX_FRAME:  prdata = {16'd0, r_cfg.max_frame_bytes};
            REG_DESCRAMBLE: prdata = {31'd0, r_cfg.descramble_enable};
            REG_CRC_POLY:   prdata = {16'd0, r_cfg.crc_poly};
            default:        prdata = {16'd0, r_cfg.crc_seed};
        endcase
    end

    sfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_op     (w_push_op)
    );

    sfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_head_op),
        .i_q_empty  (w_empty),
        .i_crc_poly (r_cfg.crc_poly),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire
